/* hw/rtl/cal_pkg.sv */
// Package for the compacting array list: default sizes, fixed port widths,
// operation codes, sequencer states and the result record.
// No dependencies.
package cal_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int KEY_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KIND_W     = 2;
    localparam int POS_W      = 7;
    localparam int KEY_W      = 64;
    localparam int PAY_W      = 32;
    localparam int CNT_OUT_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 ok;
        logic [KEY_W-1:0]     read_key;
        logic [PAY_W-1:0]     read_payload;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_full;
        logic                 is_empty;
    } t_result;

endpackage

/* hw/rtl/compacting_array_list.sv */
// Compacting array list: bounded ordered list with append, read, remove, clear.
// Append and clear go from accept straight to ST_DONE, read passes through ST_READ, and
// remove runs ST_SEARCH, then ST_SHIFT if later entries follow the match (one memory
// read and one write per cycle). One transaction in flight; the next accept comes in
// the cycle after the result leaves ST_DONE, where it waits for a free output slot.
// Synchronous active-low reset empties the list; memory contents are not cleared.
module compacting_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [POS_W-1:0]     i_position,
    input  logic [KEY_W-1:0]     i_entry_key,
    input  logic [PAY_W-1:0]     i_entry_payload,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_ok,
    output logic [KEY_W-1:0]     o_read_key,
    output logic [PAY_W-1:0]     o_read_payload,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic                 o_is_full,
    output logic                 o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int EW = KEY_BITS + PW;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;
    logic          w_push;
    logic          w_slot_free;
    t_result       w_result;
    t_result       r_res;
    logic          r_out_valid;

    assign w_slot_free = !r_out_valid || !i_stall;

    cal_store #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cal_seq #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_entry_key     (i_entry_key),
        .i_entry_payload (i_entry_payload),
        .i_slot_free     (w_slot_free),
        .o_push          (w_push),
        .o_result        (w_result),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ok           = r_res.ok;
    assign o_read_key     = r_res.read_key;
    assign o_read_payload = r_res.read_payload;
    assign o_entry_count  = r_res.entry_count;
    assign o_is_full      = r_res.is_full;
    assign o_is_empty     = r_res.is_empty;

endmodule

/* hw/rtl/cal_store.sv */
// Entry memory: one write port, one read port with registered read data.
// Each word holds a key above a payload. Depends on nothing.
module cal_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cal_seq.sv */
// Sequencer for the list: runs append, read, clear, and remove as a search
// then, if entries follow the match, a one-entry-per-cycle shift through
// the memory ports. Depends on cal_pkg; drives the cal_store ports.
module cal_seq
    import cal_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W,
    localparam int EW = KEY_BITS + PW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [KEY_W-1:0]  i_entry_key,
    input  logic [PAY_W-1:0]  i_entry_payload,
    input  logic              i_slot_free,
    output logic              o_push,
    output t_result           o_result,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [EW-1:0]     o_wdata,
    output logic [AW-1:0]     o_raddr,
    input  logic [EW-1:0]     i_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = CW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_ok, n_ok;
    logic [KEY_W-1:0]    r_rkey, n_rkey;
    logic [PAY_W-1:0]    r_rpay, n_rpay;

    logic [XW-1:0]       w_idx1, w_idx2, w_cnt;
    logic                w_pos_ok;
    logic                w_match;

    assign w_idx1   = XW'(r_idx) + XW'(1);
    assign w_idx2   = XW'(r_idx) + XW'(2);
    assign w_cnt    = XW'(r_count);
    assign w_pos_ok = (i_position != '0) && (CMPW'(i_position) <= CMPW'(r_count));
    assign w_match  = (i_rdata[EW-1 -: KEY_BITS] == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_ok   <= n_ok;
        r_rkey <= n_rkey;
        r_rpay <= n_rpay;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_key   = r_key;
        n_ok    = r_ok;
        n_rkey  = r_rkey;
        n_rpay  = r_rpay;
        o_stall = 1'b1;
        o_push  = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_idx;
        o_wdata = i_rdata;
        o_raddr = AW'(w_idx1);
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_key   = i_entry_key[KEY_BITS-1:0];
                    n_ok    = 1'b0;
                    n_rkey  = '0;
                    n_rpay  = '0;
                    n_idx   = '0;
                    n_state = ST_DONE;
                    case (t_kind'(i_kind))
                        KIND_APPEND: begin
                            if (r_count < CW'(CAPACITY)) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_count);
                                o_wdata = {i_entry_key[KEY_BITS-1:0], i_entry_payload[PW-1:0]};
                                n_count = r_count + CW'(1);
                                n_ok    = 1'b1;
                            end
                        end
                        KIND_READ: begin
                            if (w_pos_ok) begin
                                o_raddr = AW'(i_position - POS_W'(1));
                                n_state = ST_READ;
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_count != '0) begin
                                o_raddr = '0;
                                n_state = ST_SEARCH;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_ok    = 1'b1;
                n_rkey  = KEY_W'(i_rdata[EW-1 -: KEY_BITS]);
                n_rpay  = PAY_W'(i_rdata[PW-1:0]);
                n_state = ST_DONE;
            end
            ST_SEARCH: begin
                if (w_match) begin
                    if (w_idx1 < w_cnt) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_ok    = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (w_idx1 < w_cnt) begin
                    n_idx = AW'(w_idx1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                o_we    = 1'b1;
                o_raddr = AW'(w_idx2);
                if (w_idx2 < w_cnt) begin
                    n_idx = AW'(w_idx1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result.ok           = r_ok;
    assign o_result.read_key     = r_rkey;
    assign o_result.read_payload = r_rpay;
    assign o_result.entry_count  = CNT_OUT_W'(r_count);
    assign o_result.is_full      = (r_count == CW'(CAPACITY));
    assign o_result.is_empty     = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> XW'(o_waddr) <= w_cnt)
        else $error("write beyond held entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_count == $past(r_count)) ||
                                 (r_count + 1 == $past(r_count)))
        else $error("count moved by more than one removal");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_result.ok) |-> (o_result.read_key == '0) &&
                                     (o_result.read_payload == '0))
        else $error("failed transaction carries read data");

endmodule
